@@ rtl/ebss_pkg.sv @@
// Shared types, constants and helper functions for the event bank stream scanner.
// No dependencies; every other file of the block imports this package.
package ebss_pkg;

	// Depth of the queue between the front and back parts and of the result queue.
	localparam int WQ_DEPTH = 4;
	localparam int WQ_AW    = $clog2(WQ_DEPTH);
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	// Configuration register indexes and reset values.
	typedef enum logic [1:0] {
		REG_MAX_EVENT_LENGTH = 2'd0,
		REG_BANK_TAG_LIMIT   = 2'd1,
		REG_EVENT_NUMBER_TAG = 2'd2
	} reg_index_t;

	localparam logic [15:0] MAX_EVENT_LENGTH_RST = 16'd9999;
	localparam logic [15:0] BANK_TAG_LIMIT_RST   = 16'h0011;
	localparam logic [15:0] EVENT_NUMBER_TAG_RST = 16'hc000;

	// Result kinds.
	typedef enum logic [2:0] {
		KIND_EVENT_HDR = 3'd0,
		KIND_BANK_HDR  = 3'd1,
		KIND_EVENT_NUM = 3'd2,
		KIND_OVERFLOW  = 3'd3,
		KIND_BANK_END  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [15:0] max_event_length;
		logic [15:0] bank_tag_limit;
		logic [15:0] event_number_tag;
	} cfg_t;

	// One body word travelling from the front part to the back part.
	typedef struct packed {
		logic        valid;
		logic [31:0] word;
	} word_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] size_words;
		logic [15:0] tag;
		logic [7:0]  dtype;
		logic [7:0]  number;
		logic [31:0] event_number;
		logic        last;
	} result_t;

	localparam result_t NO_RESULT = '0;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic result_t make_result(input kind_t k, input logic [31:0] size,
			input logic [31:0] hdr, input logic [31:0] evnum);
		result_t r;
		r.kind         = k;
		r.size_words   = size;
		r.tag          = hdr[31:16];
		r.dtype        = hdr[15:8];
		r.number       = hdr[7:0];
		r.event_number = evnum;
		r.last         = 1'b0;
		return r;
	endfunction

endpackage

@@ rtl/ebss_front.sv @@
// Front part: byte swap, block length capture and block header removal.
// Depends on ebss_pkg; feeds body words into ebss_wq.
module ebss_front import ebss_pkg::*; #(
	parameter int BLOCK_HEADER_WORDS = 8,
	parameter int SKIP_W             = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] raw_word,
	input  logic        wq_full,
	output word_item_t  push
);

	localparam logic [SKIP_W-1:0] SKIP_INIT = SKIP_W'(BLOCK_HEADER_WORDS - 1);

	logic              first_q;
	logic [31:0]       blen_q;
	logic [31:0]       bpos_q;
	logic [SKIP_W-1:0] skip_q;
	logic              accept;
	logic [31:0]       w;

	assign in_ready = !wq_full;
	assign accept   = in_valid && in_ready;
	assign w        = swap32(raw_word);

	// A word is a body word when it lies neither in the first nor in a later block header.
	always_comb begin
		push.word  = w;
		push.valid = accept && !first_q && (skip_q == '0) && (bpos_q < blen_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			blen_q  <= '0;
			bpos_q  <= '0;
			skip_q  <= '0;
		end else if (accept) begin
			if (first_q) begin
				first_q <= 1'b0;
				blen_q  <= w;
				bpos_q  <= 32'd1;
				skip_q  <= SKIP_INIT;
			end else if (skip_q != '0) begin
				skip_q <= skip_q - 1'b1;
				bpos_q <= bpos_q + 32'd1;
			end else if (bpos_q >= blen_q) begin
				bpos_q <= 32'd1;
				skip_q <= SKIP_INIT;
			end else begin
				bpos_q <= bpos_q + 32'd1;
			end
		end
	end

endmodule

@@ rtl/ebss_wq.sv @@
// Short word queue between the front and back parts.
// Depends on ebss_pkg for the item type and depth.
module ebss_wq import ebss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  word_item_t push,
	input  logic       pop,
	output word_item_t head,
	output logic       full
);

	logic [31:0]      mem_q [WQ_DEPTH];
	logic [WQ_AW-1:0] wr_q;
	logic [WQ_AW-1:0] rd_q;
	logic [WQ_AW:0]   cnt_q;

	assign full       = (cnt_q == (WQ_AW+1)'(WQ_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.word  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (WQ_AW+1)'(push.valid) - (WQ_AW+1)'(pop);
		end
	end

endmodule

@@ rtl/ebss_back.sv @@
// Back part: event and bank parser that turns body words into result records.
// Depends on ebss_pkg; reads ebss_wq and writes up to two records into ebss_rq.
module ebss_back import ebss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  word_item_t head,
	output logic       pop,
	input  logic       rq_space,
	output result_t    push0,
	output result_t    push1,
	output logic [1:0] push_cnt
);

	typedef enum logic [2:0] {
		PH_LENGTH, PH_EVHDR, PH_EVSKIP, PH_BSIZE, PH_BHDR, PH_BDATA
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [31:0] ewl_q, ewl_n;
	logic [31:0] bwl_q, bwl_n;
	logic        bo_q, bo_n;
	logic        np_q, np_n;
	logic        halted_q, halted_n;
	logic [1:0]  n;
	result_t     r0, r1;
	logic [31:0] w;
	logic [31:0] left_after;
	logic        err;

	assign pop      = head.valid && rq_space;
	assign push0    = r0;
	assign push1    = r1;
	assign push_cnt = pop ? n : 2'd0;

	always_comb begin
		phase_n    = phase_q;
		ewl_n      = ewl_q;
		bwl_n      = bwl_q;
		bo_n       = bo_q;
		np_n       = np_q;
		halted_n   = halted_q;
		n          = 2'd0;
		r0         = NO_RESULT;
		r1         = NO_RESULT;
		err        = 1'b0;
		w          = head.word;
		left_after = ewl_q - 32'd1;
		if (!halted_q) begin
			if (phase_q == PH_LENGTH) begin
				if (w != '0) begin
					if (w > {16'd0, cfg.max_event_length}) begin
						r0       = make_result(KIND_OVERFLOW, w, '0, '0);
						n        = 2'd1;
						halted_n = 1'b1;
					end else begin
						ewl_n   = w;
						phase_n = PH_EVHDR;
					end
				end
			end else begin
				if (phase_q == PH_EVHDR) begin
					r0      = make_result(KIND_EVENT_HDR, ewl_q, w, '0);
					n       = 2'd1;
					np_n    = 1'b0;
					bo_n    = 1'b0;
					phase_n = (w[31:16] < cfg.bank_tag_limit) ? PH_BSIZE : PH_EVSKIP;
				end else begin
					if (np_q) begin
						r0   = make_result(KIND_EVENT_NUM, '0, '0, w);
						n    = 2'd1;
						np_n = 1'b0;
					end
					case (phase_q)
						PH_BSIZE: begin
							bwl_n   = w;
							phase_n = PH_BHDR;
						end
						PH_BHDR: begin
							if (n == 2'd0) begin
								r0 = make_result(KIND_BANK_HDR, bwl_q, w, '0);
							end else begin
								r1 = make_result(KIND_BANK_HDR, bwl_q, w, '0);
							end
							n = n + 2'd1;
							if (w[31:16] == cfg.event_number_tag) begin
								np_n = 1'b1;
							end
							if (bwl_q == '0) begin
								// A zero size makes this header word the next size word too.
								bwl_n = w;
							end else if (bwl_q == 32'd1) begin
								phase_n = PH_BSIZE;
							end else begin
								bwl_n = bwl_q - 32'd1;
								if ((bwl_q - 32'd1) > left_after) begin
									bo_n = 1'b1;
								end
								phase_n = PH_BDATA;
							end
						end
						PH_BDATA: begin
							bwl_n = bwl_q - 32'd1;
							if (bwl_q == 32'd1) begin
								phase_n = PH_BSIZE;
							end
						end
						default: ;
					endcase
				end
				ewl_n = left_after;
				if (ewl_q == 32'd1) begin
					err = bo_n || (phase_n == PH_BDATA) ||
						((phase_n == PH_BHDR) && (bwl_n != '0));
					if (err) begin
						// The error takes the second slot when a result already exists, overwriting any second result.
						if (n == 2'd0) begin
							r0 = make_result(KIND_BANK_END, '0, '0, '0);
							n  = 2'd1;
						end else begin
							r1 = make_result(KIND_BANK_END, '0, '0, '0);
							n  = 2'd2;
						end
						halted_n = 1'b1;
					end
					np_n    = 1'b0;
					bo_n    = 1'b0;
					phase_n = PH_LENGTH;
				end
			end
		end
		if (n == 2'd1) begin
			r0.last = 1'b1;
		end else if (n == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LENGTH;
			ewl_q    <= '0;
			bwl_q    <= '0;
			bo_q     <= 1'b0;
			np_q     <= 1'b0;
			halted_q <= 1'b0;
		end else if (pop) begin
			phase_q  <= phase_n;
			ewl_q    <= ewl_n;
			bwl_q    <= bwl_n;
			bo_q     <= bo_n;
			np_q     <= np_n;
			halted_q <= halted_n;
		end
	end

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted state was left without reset");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> (push_cnt == 2'd0))
		else $error("results produced while halted");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt == 2'd2) |->
			((push0.kind == KIND_EVENT_NUM) || (push0.kind == KIND_BANK_HDR)) &&
			push1.last && !push0.last)
		else $error("two-result word with unexpected first kind or last flags");

endmodule

@@ rtl/ebss_rq.sv @@
// Result queue: takes up to two records a cycle, hands out one a cycle while out_ready is high.
// Depends on ebss_pkg for the record type and depth.
module ebss_rq import ebss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  result_t    push0,
	input  result_t    push1,
	input  logic [1:0] push_cnt,
	output logic       space2,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    head
);

	result_t          mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_q;
	logic [RQ_AW-1:0] rd_q;
	logic [RQ_AW:0]   cnt_q;
	logic             pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	assign space2    = (cnt_q <= (RQ_AW+1)'(RQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_q + 1'b1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + RQ_AW'(push_cnt);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (RQ_AW+1)'(push_cnt) - (RQ_AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> space2)
		else $error("result queue written without room for two records");

endmodule

@@ rtl/event_bank_stream_scanner.sv @@
// Top level of the event bank stream scanner: configuration registers and part wiring.
// Depends on ebss_pkg, ebss_front, ebss_wq, ebss_back and ebss_rq.

// The scanner takes one 32-bit file word per transaction, swaps its bytes, and
// parses the blocked event format: the first block header word sets the block
// length, block headers are dropped wherever they fall, and each event's length
// word and header are reported, along with bank headers and the event number
// for events whose tag is below bank_tag_limit. An oversize event or a bank
// that does not end on the event boundary reports an error and the scanner
// then ignores all further words until reset. Input transactions are taken
// one per clock while the word queue is not full: the front part removes
// block headers and writes body words into a four-entry word queue, and the
// back part parses one queued word per clock when the four-entry result queue
// has room for two records. Results leave one per clock while out_ready is
// high, so when many words each yield two results the output cannot keep up
// and room in the result queue limits sustained throughput. A result passes
// through the word queue and then the result queue before it is presented on
// the output. Configuration writes take effect at the next clock and should
// be made while the scanner is idle; no clearing pass is needed after reset.
module event_bank_stream_scanner import ebss_pkg::*; #(
	parameter int BLOCK_HEADER_WORDS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] raw_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] size_words,
	output logic [15:0] tag,
	output logic [7:0]  dtype,
	output logic [7:0]  number,
	output logic [31:0] event_number,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Wide enough to hold the header length minus one, at least one bit.
	localparam int SKIP_W = $clog2(BLOCK_HEADER_WORDS + 1);

	cfg_t       cfg_q;
	word_item_t wq_push;
	word_item_t wq_head;
	logic       wq_full;
	logic       wq_pop;
	result_t    rq_push0;
	result_t    rq_push1;
	logic [1:0] rq_push_cnt;
	logic       rq_space2;
	result_t    rq_head;

	// Writes to an index beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_event_length <= MAX_EVENT_LENGTH_RST;
			cfg_q.bank_tag_limit   <= BANK_TAG_LIMIT_RST;
			cfg_q.event_number_tag <= EVENT_NUMBER_TAG_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_MAX_EVENT_LENGTH: cfg_q.max_event_length <= cfg_data;
				REG_BANK_TAG_LIMIT:   cfg_q.bank_tag_limit   <= cfg_data;
				REG_EVENT_NUMBER_TAG: cfg_q.event_number_tag <= cfg_data;
				default: ;
			endcase
		end
	end

	ebss_front #(
		.BLOCK_HEADER_WORDS(BLOCK_HEADER_WORDS),
		.SKIP_W(SKIP_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_word(raw_word),
		.wq_full(wq_full),
		.push(wq_push)
	);

	ebss_wq u_wq (
		.clk(clk),
		.arst_n(arst_n),
		.push(wq_push),
		.pop(wq_pop),
		.head(wq_head),
		.full(wq_full)
	);

	ebss_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(wq_head),
		.pop(wq_pop),
		.rq_space(rq_space2),
		.push0(rq_push0),
		.push1(rq_push1),
		.push_cnt(rq_push_cnt)
	);

	ebss_rq u_rq (
		.clk(clk),
		.arst_n(arst_n),
		.push0(rq_push0),
		.push1(rq_push1),
		.push_cnt(rq_push_cnt),
		.space2(rq_space2),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head(rq_head)
	);

	assign kind         = rq_head.kind;
	assign size_words   = rq_head.size_words;
	assign tag          = rq_head.tag;
	assign dtype        = rq_head.dtype;
	assign number       = rq_head.number;
	assign event_number = rq_head.event_number;
	assign last         = rq_head.last;

endmodule
